/* rtl/button_debounce_lockout_macros.svh */
// Assertion macros used by the debounce block's top level.
`ifndef BUTTON_DEBOUNCE_LOCKOUT_MACROS_SVH
`define BUTTON_DEBOUNCE_LOCKOUT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define BDL_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define BDL_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define BDL_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define BDL_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

/* rtl/bdl_pkg.sv */
// Types and constants shared by the button debounce block.
package bdl_pkg;

  localparam int BUTTONS      = 12;
  localparam int TIME_BITS    = 32;
  localparam int BOUNCE_W     = 16;
  localparam int QUERY_W      = 4;
  localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 16'd16;

  typedef struct packed {
    logic [BUTTONS-1:0]   sampled_lines;
    logic [TIME_BITS-1:0] now_ms;
    logic [QUERY_W-1:0]   query_button;
  } in_t;

  typedef struct packed {
    logic [BUTTONS-1:0]   pressed_mask;
    logic [BUTTONS-1:0]   changed_mask;
    logic [BUTTONS-1:0]   press_edges;
    logic [BUTTONS-1:0]   release_edges;
    logic [TIME_BITS-1:0] held_time;
  } out_t;

  // What one button lane reports for the request just taken.
  typedef struct packed {
    logic                 pressed;
    logic                 changed;
    logic [TIME_BITS-1:0] held;
  } lane_t;

endpackage

/* rtl/bdl_lane.sv */
// One button lane: debounced state, last change time and lockout check.
module bdl_lane
  import bdl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 line_level,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [BOUNCE_W-1:0]  bounce_ms,
  output lane_t                result
);

  logic                 state;
  logic                 state_next;
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] elapsed;
  logic                 flip;

  always_comb begin
    elapsed    = now_ms - last_time;
    // A low line means pressed; flip only once the lockout has run out.
    flip       = (~line_level != state) && (elapsed > TIME_BITS'(bounce_ms));
    state_next = state ^ flip;
    result.pressed = state_next;
    result.changed = flip;
    if (state_next && !flip) begin
      result.held = elapsed;
    end else begin
      result.held = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= 1'b0;
      last_time <= '0;
    end else if (accept) begin
      state <= state_next;
      if (flip) begin
        last_time <= now_ms;
      end
    end
  end

endmodule

/* rtl/bdl_merge.sv */
// Merge stage: gathers the lane results into masks and the queried held time.
module bdl_merge
  import bdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               lanes_valid,
  output logic               lanes_ready,
  input  lane_t              lanes [BUTTONS],
  input  logic [QUERY_W-1:0] query_button,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data
);

  out_t merged;

  always_comb begin
    merged = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      merged.pressed_mask[BUTTONS-1-i]  = lanes[i].pressed;
      merged.changed_mask[BUTTONS-1-i]  = lanes[i].changed;
      merged.press_edges[BUTTONS-1-i]   = lanes[i].changed & lanes[i].pressed;
      merged.release_edges[BUTTONS-1-i] = lanes[i].changed & ~lanes[i].pressed;
      if (query_button == QUERY_W'(i)) begin
        merged.held_time = lanes[i].held;
      end
    end
  end

  assign lanes_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lanes_ready) begin
      out_valid <= lanes_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lanes_ready && lanes_valid) begin
      out_data <= merged;
    end
  end

endmodule

/* rtl/button_debounce_lockout.sv */
// Top level of the twelve-button time-lockout debounce block.
// Each request carries the sampled line levels of twelve buttons (a low line
// means pressed), a wrapping millisecond timestamp and the index of one button
// whose held time is wanted. A button's debounced state flips only when its
// line disagrees with it and more than bounce_ms milliseconds, counted modulo
// 2^32, have passed since that button's last accepted change. The block takes
// one request per clock cycle unless stalled and delivers its result through
// two registers: twelve lanes update their state and time registers in the
// cycle of acceptance into a lane result register, and a merge stage builds
// the masks and selects the queried held time into the output register. When
// the output stalls, the two registers hold two results before input stalls.
// A query of twelve or more, or of a released button, gives a held time of 0.
// bounce_ms resets to 16 and should be written only while the block is idle.
module button_debounce_lockout
  import bdl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [BOUNCE_W-1:0] cfg_data
);

`include "button_debounce_lockout_macros.svh"

  // Lockout time register.
  logic [BOUNCE_W-1:0] bounce_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_ms <= BOUNCE_RESET;
    end else if (cfg_we) begin
      bounce_ms <= cfg_data;
    end
  end

  logic accept;
  assign accept = in_valid && in_ready;

  // Per-button lanes. Button i sits on line bit BUTTONS-1-i.
  lane_t lane_res [BUTTONS];

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    bdl_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .accept     (accept),
      .line_level (in_data.sampled_lines[BUTTONS-1-i]),
      .now_ms     (in_data.now_ms),
      .bounce_ms  (bounce_ms),
      .result     (lane_res[i])
    );
  end

  // Lane result register between the lanes and the merge stage. The lane
  // state is already committed, so this register only carries the findings.
  logic               s1_valid;
  logic               s1_ready;
  lane_t              s1_lanes [BUTTONS];
  logic [QUERY_W-1:0] s1_query;

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lanes <= lane_res;
      s1_query <= in_data.query_button;
    end
  end

  bdl_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .lanes_valid  (s1_valid),
    .lanes_ready  (s1_ready),
    .lanes        (s1_lanes),
    .query_button (s1_query),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // A button cannot both press and release on one request.
  `BDL_ASSERT_IMPLIES(a_edges_disjoint, clk, rst, out_valid, (out_data.press_edges & out_data.release_edges) == '0)
  // A nonzero held time belongs to a pressed button.
  `BDL_ASSERT_IMPLIES(a_held_needs_press, clk, rst, out_valid && (out_data.held_time != '0), out_data.pressed_mask != '0)
  // An accepted request always lands in the lane result register.
  `BDL_ASSERT_NEXT(a_accept_fills_s1, clk, rst, accept, s1_valid)

endmodule
